/* design/assert_macros.svh */
// Assertion macros used by the checker file of the accessory ID classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define AIC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define AIC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/aic_pkg.sv */
// Types and constants of the accessory ID classifier.
`timescale 1ns / 1ps

package aic_pkg;

	localparam int CNT_W = 4;

	typedef enum logic [3:0] {
		T_UNDOCKED = 4'd0,
		T_UNDEF    = 4'd1,
		T_DESK     = 4'd2,
		T_CAR      = 4'd3,
		T_HEADSET  = 4'd4,
		T_DMB      = 4'd5,
		T_MHL      = 4'd6,
		T_ADOCK    = 4'd7,
		T_HOST     = 4'd8
	} aic_type_t;

	// configuration register indexes
	localparam logic [2:0] CFG_ADC_DETECT = 3'd0;
	localparam logic [2:0] CFG_MHL_SUPP   = 3'd1;
	localparam logic [2:0] CFG_MHL_FORCED = 3'd2;
	localparam logic [2:0] CFG_HOST_SUPP  = 3'd3;
	localparam logic [2:0] CFG_HS_DMB_WIN = 3'd4;

	// headset event, USB path and host notify codes
	localparam logic [1:0] HS_NONE      = 2'd0;
	localparam logic [1:0] HS_USB_AUDIO = 2'd1;
	localparam logic [1:0] HS_NO_HS     = 2'd2;
	localparam logic [1:0] PATH_KEEP    = 2'd0;
	localparam logic [1:0] PATH_AUDIO   = 2'd1;
	localparam logic [1:0] PATH_TO_USB  = 2'd2;
	localparam logic [1:0] HOST_NONE    = 2'd0;
	localparam logic [1:0] HOST_CONN    = 2'd1;
	localparam logic [1:0] HOST_DISC    = 2'd2;

	// first reading windows, bounds exclusive
	localparam logic signed [12:0] A_MID_LO  = -13'sd100;
	localparam logic signed [12:0] A_MID_HI  = 13'sd100;
	localparam logic signed [12:0] A_CAR_LO  = 13'sd150;
	localparam logic signed [12:0] A_CAR_HI  = 13'sd220;
	localparam logic signed [12:0] A_HS_LO   = 13'sd370;
	localparam logic signed [12:0] A_HS_HI   = 13'sd440;
	localparam logic signed [12:0] A_DMB_HI  = 13'sd550;
	localparam logic signed [12:0] A_DESK_HI = 13'sd900;

	// second reading windows, bounds inclusive
	localparam logic [11:0] S_MHL_LO = 12'd776;
	localparam logic [11:0] S_MHL_HI = 12'd1020;
	localparam logic [11:0] S_AD_LO  = 12'd1021;
	localparam logic [11:0] S_AD_HI  = 12'd1224;

	typedef struct packed {
		logic adc_detect_enable;
		logic mhl_supported;
		logic mhl_forced;
		logic usb_host_supported;
		logic headset_dmb_windows;
	} aic_cfg_t;

	typedef struct packed {
		logic       type_stable;
		aic_type_t  sample_type;
		aic_type_t  accessory_now;
		logic       switch_written;
		aic_type_t  switch_value;
		logic [1:0] headset_event;
		logic [1:0] usb_path;
		logic       charge_clear;
		logic [1:0] host_notify;
		logic       irq_enable;
		logic       irq_trigger_high;
	} aic_result_t;

endpackage

/* design/aic_classify.sv */
// Window classifier: maps one ID sample to an accessory type.
`timescale 1ns / 1ps

module aic_classify import aic_pkg::*; (
	input  aic_cfg_t           cfg,
	input  logic               id_pin_high,
	input  logic               redetect,
	input  logic signed [12:0] adc_first,
	input  logic [11:0]        adc_second,
	output aic_type_t          sample_type
);

	aic_type_t second_type;

	always_comb begin
		priority if (cfg.mhl_forced || (adc_second >= S_MHL_LO && adc_second <= S_MHL_HI)) begin
			second_type = cfg.mhl_supported ? T_MHL : T_UNDEF;
		end else if (adc_second >= S_AD_LO && adc_second <= S_AD_HI) begin
			second_type = T_ADOCK;
		end else begin
			second_type = cfg.usb_host_supported ? T_HOST : T_UNDEF;
		end
	end

	always_comb begin
		priority if (id_pin_high && !redetect) begin
			sample_type = T_UNDOCKED;
		end else if (adc_first > A_MID_LO && adc_first < A_MID_HI) begin
			sample_type = second_type;
		end else if (adc_first > A_CAR_LO && adc_first < A_CAR_HI) begin
			sample_type = T_CAR;
		end else if (cfg.headset_dmb_windows && adc_first > A_HS_LO && adc_first < A_HS_HI) begin
			sample_type = T_HEADSET;
		end else if (cfg.headset_dmb_windows && adc_first > A_HS_HI && adc_first < A_DMB_HI) begin
			sample_type = T_DMB;
		end else if (adc_first > A_DMB_HI && adc_first < A_DESK_HI) begin
			sample_type = T_DESK;
		end else begin
			sample_type = T_UNDEF;
		end
	end

endmodule

/* design/aic_tracker.sv */
// Debounce counter and accessory state: turns a classified type into actions.
`timescale 1ns / 1ps

module aic_tracker import aic_pkg::*; #(
	parameter int STABLE_SAMPLES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic        adc_detect_enable,
	input  logic        id_pin_high,
	input  aic_type_t   class_type,
	output aic_result_t result
);

	localparam logic [CNT_W-1:0] STABLE_CNT = CNT_W'(STABLE_SAMPLES);

	aic_type_t        last_type_q;
	logic [CNT_W-1:0] repeat_q;
	aic_type_t        acc_q;
	aic_type_t        sw_q;

	logic [CNT_W-1:0] rc_base;
	logic [CNT_W-1:0] rc_next;
	logic             stable;
	aic_type_t        cur_type;
	aic_type_t        acc_next;
	aic_type_t        sw_next;
	logic             sw_w;
	logic [1:0]       hs;
	logic [1:0]       path;
	logic             chg;
	logic [1:0]       host;
	logic             irq_en;
	logic             irq_hi;

	always_comb begin
		rc_base = (repeat_q >= STABLE_CNT) ? '0 : repeat_q;
		rc_next = (class_type == last_type_q) ? rc_base + 1'b1 : '0;
		stable  = !adc_detect_enable || (rc_next >= STABLE_CNT);
		cur_type = adc_detect_enable ? class_type : T_UNDOCKED;
	end

	always_comb begin
		acc_next = acc_q;
		sw_next  = sw_q;
		sw_w     = 1'b0;
		hs       = HS_NONE;
		path     = PATH_KEEP;
		chg      = 1'b0;
		host     = HOST_NONE;

		// leaving audio dock for any real accessory
		if (acc_q == T_ADOCK && cur_type != T_UNDEF && cur_type != T_UNDOCKED) begin
			sw_w     = 1'b1;
			sw_next  = T_UNDOCKED;
			hs       = HS_NO_HS;
			acc_next = T_UNDOCKED;
		end

		unique case (cur_type)
			T_DESK, T_CAR, T_MHL, T_DMB, T_HOST: begin
				sw_w     = 1'b1;
				sw_next  = cur_type;
				acc_next = cur_type;
				chg      = (cur_type == T_DMB);
				if (cur_type == T_HOST) host = HOST_CONN;
			end
			T_HEADSET: begin
				acc_next = T_HEADSET;
				path     = PATH_AUDIO;
				hs       = HS_USB_AUDIO;
			end
			T_ADOCK: begin
				sw_w     = 1'b1;
				sw_next  = T_DESK;
				acc_next = T_ADOCK;
			end
			T_UNDEF, T_UNDOCKED: begin
				// removal
				unique case (acc_q)
					T_DESK, T_CAR, T_DMB: begin
						sw_w     = 1'b1;
						sw_next  = T_UNDOCKED;
						acc_next = T_UNDOCKED;
					end
					T_HEADSET: begin
						hs       = HS_NO_HS;
						path     = PATH_TO_USB;
						acc_next = T_UNDOCKED;
					end
					T_MHL: begin
						sw_w    = 1'b1;
						sw_next = T_UNDOCKED;
					end
					T_HOST: begin
						host     = HOST_DISC;
						sw_w     = 1'b1;
						sw_next  = T_UNDOCKED;
						acc_next = T_UNDOCKED;
					end
					T_ADOCK: begin
						sw_w     = 1'b1;
						sw_next  = T_UNDOCKED;
						hs       = HS_NO_HS;
						acc_next = T_UNDOCKED;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		irq_en = (acc_next != T_MHL);
		irq_hi = 1'b0;
		if (acc_next != T_MHL) irq_hi = (acc_next == T_UNDOCKED) ? !id_pin_high : 1'b1;
	end

	always_comb begin
		result.type_stable   = stable;
		result.sample_type   = cur_type;
		result.accessory_now = stable ? acc_next : acc_q;
		result.switch_written = stable & sw_w;
		result.switch_value  = stable ? sw_next : sw_q;
		result.headset_event = stable ? hs : HS_NONE;
		result.usb_path      = stable ? path : PATH_KEEP;
		result.charge_clear  = stable & chg;
		result.host_notify   = stable ? host : HOST_NONE;
		result.irq_enable    = stable & irq_en;
		result.irq_trigger_high = stable & irq_hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_type_q <= T_UNDOCKED;
			repeat_q    <= '0;
			acc_q       <= T_UNDOCKED;
			sw_q        <= T_UNDOCKED;
		end else if (advance) begin
			if (adc_detect_enable) begin
				last_type_q <= class_type;
				repeat_q    <= rc_next;
			end
			if (stable) begin
				acc_q <= acc_next;
				sw_q  <= sw_next;
			end
		end
	end

endmodule

/* design/accessory_id_classifier.sv */
// Top level of the accessory ID classifier.
`timescale 1ns / 1ps
//
// One ID-pin sample enters per word on the s_axis channel; one result word
// leaves on the m_axis channel for every sample, in order.
// A sample is held in an input register, classified and run through the
// debounce counter and accessory state in one combinational pass, and the
// result lands in the output register, which drives m_axis_tvalid; one word
// per cycle while the receiver does not stall. m_axis_tuser is 1 once the
// type has repeated STABLE_SAMPLES times after its first sighting, or while
// detection is off, and its actions apply; 0 marks a pending sample.
// Configuration is written through cfg_we / cfg_index / cfg_data and takes
// effect on the next sample; write only while the block is empty.
// Reset clears the stored accessory, dock switch value and debounce state to
// undocked and restores the default configuration. When the receiver stalls
// the output word holds, one sample waits in the input register and
// s_axis_tready drops until the output moves.
//
module accessory_id_classifier import aic_pkg::*; #(
	parameter int STABLE_SAMPLES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // adc_first[12:0], adc_second[24:13], zero
	input  logic [1:0]  s_axis_tuser,  // id_pin_high[0], redetect[1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // sample_type, accessory_now, switch_written,
	                                   // switch_value, headset_event, usb_path,
	                                   // charge_clear, host_notify, irq_enable,
	                                   // irq_trigger_high, zero
	output logic        m_axis_tuser,  // type_stable
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic        cfg_data
);

	aic_cfg_t           cfg_q;
	logic               valid_s1;
	logic               pin_s1;
	logic               redet_s1;
	logic signed [12:0] adc_first_s1;
	logic [11:0]        adc_second_s1;
	logic               valid_s2;
	aic_result_t        res_s2;
	logic               advance;
	aic_type_t          class_type;
	aic_result_t        result;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adc_detect_enable   <= 1'b1;
			cfg_q.mhl_supported       <= 1'b1;
			cfg_q.mhl_forced          <= 1'b0;
			cfg_q.usb_host_supported  <= 1'b1;
			cfg_q.headset_dmb_windows <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ADC_DETECT: cfg_q.adc_detect_enable   <= cfg_data;
				CFG_MHL_SUPP:   cfg_q.mhl_supported       <= cfg_data;
				CFG_MHL_FORCED: cfg_q.mhl_forced          <= cfg_data;
				CFG_HOST_SUPP:  cfg_q.usb_host_supported  <= cfg_data;
				CFG_HS_DMB_WIN: cfg_q.headset_dmb_windows <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			pin_s1        <= s_axis_tuser[0];
			redet_s1      <= s_axis_tuser[1];
			adc_first_s1  <= s_axis_tdata[12:0];
			adc_second_s1 <= s_axis_tdata[24:13];
		end
	end

	aic_classify u_classify (
		.cfg         (cfg_q),
		.id_pin_high (pin_s1),
		.redetect    (redet_s1),
		.adc_first   (adc_first_s1),
		.adc_second  (adc_second_s1),
		.sample_type (class_type)
	);

	aic_tracker #(
		.STABLE_SAMPLES (STABLE_SAMPLES)
	) u_tracker (
		.clk               (clk),
		.arst_n            (arst_n),
		.advance           (advance),
		.adc_detect_enable (cfg_q.adc_detect_enable),
		.id_pin_high       (pin_s1),
		.class_type        (class_type),
		.result            (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.type_stable;
	assign m_axis_tdata  = {2'b00,
	                        res_s2.irq_trigger_high,
	                        res_s2.irq_enable,
	                        res_s2.host_notify,
	                        res_s2.charge_clear,
	                        res_s2.usb_path,
	                        res_s2.headset_event,
	                        res_s2.switch_value,
	                        res_s2.switch_written,
	                        res_s2.accessory_now,
	                        res_s2.sample_type};

endmodule

/* design/aic_checker.sv */
// Port-level checks of the accessory ID classifier, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aic_checker import aic_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        cfg_we,
	input logic [2:0]  cfg_index,
	input logic        cfg_data
);

	logic        pend_word;
	logic        acc_word;
	logic        out_stall;
	logic        no_actions;
	logic        irq_en_ok;
	logic        types_ok;
	logic [24:0] out_word;

	assign pend_word  = m_axis_tvalid && !m_axis_tuser;
	assign acc_word   = m_axis_tvalid && m_axis_tuser;
	assign out_stall  = m_axis_tvalid && !m_axis_tready;
	assign no_actions = !m_axis_tdata[8] && (m_axis_tdata[21:13] == '0);
	assign irq_en_ok  = m_axis_tdata[20] == (m_axis_tdata[7:4] != T_MHL);
	assign types_ok   = m_axis_tdata[3:0] <= T_HOST && m_axis_tdata[7:4] <= T_HOST
		&& m_axis_tdata[12:9] <= T_HOST;
	assign out_word   = {m_axis_tuser, m_axis_tdata};

	// a pending word carries no actions
	`AIC_ASSERT_NOW(a_pending_quiet, pend_word, no_actions, "pending word carries actions")

	// interrupt re-armed exactly when an accepted state is not MHL
	`AIC_ASSERT_NOW(a_irq_mhl, acc_word, irq_en_ok, "irq enable disagrees with MHL state")

	// reported types stay within the encoding
	`AIC_ASSERT_NOW(a_type_range, m_axis_tvalid, types_ok, "type code out of range")

	// a stalled result word holds
	`AIC_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "stalled word changed")

endmodule

bind accessory_id_classifier aic_checker u_aic_checker (.*);

/* dv/accessory_id_classifier_tb.sv */
// Self-checking testbench for the accessory ID classifier stream block.
`timescale 1ns / 1ps

module accessory_id_classifier_tb;
	import aic_pkg::*;

	localparam int STABLE_SAMPLES = 3;
	localparam int MAX_REPORTS    = 60;

	// stimulus classes, R_NOISE last
	typedef enum int {
		R_PIN_HIGH, R_MHL_WIN, R_DOCK_WIN, R_OTHER_SECOND, R_CAR,
		R_HEADSET, R_DMB, R_DESK, R_OUTSIDE, R_NOISE
	} region_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_axis_tvalid;
	logic        m_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic        cfg_data;

	accessory_id_classifier #(.STABLE_SAMPLES(STABLE_SAMPLES)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// predictor state
	aic_cfg_t    cur_cfg     = aic_cfg_t'(5'b11011);
	aic_type_t   last_kind   = T_UNDOCKED;
	logic [3:0]  hit_count   = '0;
	aic_type_t   acc_state   = T_UNDOCKED;
	aic_type_t   sw_model    = T_UNDOCKED;

	aic_result_t pending_results [$];
	aic_result_t want_r;

	int   mismatches     = 0;
	int   samples_sent   = 0;
	int   results_seen   = 0;
	int   accepted_types = 0;
	int   cfg_settings   = 0;
	logic [8:0] kinds_reached = '0;

	bit tx_gaps     = 1'b1;
	bit rx_gaps     = 1'b1;
	bit quiet       = 1'b0;
	int rx_hold_req = 0;

	function automatic aic_type_t classify_id(input logic pin, input logic redet,
		input logic signed [12:0] a, input logic [11:0] s);
		if (pin && !redet)
			return T_UNDOCKED;
		if (a > A_MID_LO && a < A_MID_HI) begin
			if (cur_cfg.mhl_forced || (s >= S_MHL_LO && s <= S_MHL_HI))
				return cur_cfg.mhl_supported ? T_MHL : T_UNDEF;
			if (s >= S_AD_LO && s <= S_AD_HI)
				return T_ADOCK;
			return cur_cfg.usb_host_supported ? T_HOST : T_UNDEF;
		end
		if (a > A_CAR_LO && a < A_CAR_HI)
			return T_CAR;
		if (cur_cfg.headset_dmb_windows && a > A_HS_LO && a < A_HS_HI)
			return T_HEADSET;
		if (cur_cfg.headset_dmb_windows && a > A_HS_HI && a < A_DMB_HI)
			return T_DMB;
		if (a > A_DMB_HI && a < A_DESK_HI)
			return T_DESK;
		return T_UNDEF;
	endfunction

	// debounce, accessory state update and action reporting for one sample
	function automatic void predict_classification(input logic pin, input logic redet,
		input logic signed [12:0] a, input logic [11:0] s, output aic_result_t r);
		aic_type_t kind;
		r = '0;
		if (cur_cfg.adc_detect_enable) begin
			if (hit_count >= STABLE_SAMPLES)
				hit_count = '0;
			kind = classify_id(pin, redet, a, s);
			if (kind == last_kind)
				hit_count = hit_count + 1'b1;
			else
				hit_count = '0;
			last_kind = kind;
			if (hit_count < STABLE_SAMPLES) begin
				r.sample_type   = kind;
				r.accessory_now = acc_state;
				r.switch_value  = sw_model;
				return;
			end
		end else begin
			kind = T_UNDOCKED;
		end

		// any real accessory knocks the audio dock out first
		if (acc_state == T_ADOCK && kind != T_UNDEF && kind != T_UNDOCKED) begin
			r.switch_written = 1'b1;
			sw_model         = T_UNDOCKED;
			r.headset_event  = HS_NO_HS;
			acc_state        = T_UNDOCKED;
		end

		case (kind)
			T_DESK, T_CAR, T_MHL, T_DMB, T_HOST: begin
				r.switch_written = 1'b1;
				sw_model         = kind;
				acc_state        = kind;
				if (kind == T_DMB)
					r.charge_clear = 1'b1;
				if (kind == T_HOST)
					r.host_notify = HOST_CONN;
			end
			T_HEADSET: begin
				acc_state       = T_HEADSET;
				r.usb_path      = PATH_AUDIO;
				r.headset_event = HS_USB_AUDIO;
			end
			T_ADOCK: begin
				r.switch_written = 1'b1;
				sw_model         = T_DESK;
				acc_state        = T_ADOCK;
			end
			default: begin
				case (acc_state)
					T_DESK, T_CAR, T_DMB: begin
						r.switch_written = 1'b1;
						sw_model         = T_UNDOCKED;
						acc_state        = T_UNDOCKED;
					end
					T_HEADSET: begin
						r.headset_event = HS_NO_HS;
						r.usb_path      = PATH_TO_USB;
						acc_state       = T_UNDOCKED;
					end
					T_MHL: begin
						// switch drops, state stays MHL
						r.switch_written = 1'b1;
						sw_model         = T_UNDOCKED;
					end
					T_HOST: begin
						r.host_notify    = HOST_DISC;
						r.switch_written = 1'b1;
						sw_model         = T_UNDOCKED;
						acc_state        = T_UNDOCKED;
					end
					T_ADOCK: begin
						r.switch_written = 1'b1;
						sw_model         = T_UNDOCKED;
						r.headset_event  = HS_NO_HS;
						acc_state        = T_UNDOCKED;
					end
					default: begin
					end
				endcase
			end
		endcase

		if (acc_state != T_MHL) begin
			r.irq_enable       = 1'b1;
			r.irq_trigger_high = (acc_state == T_UNDOCKED) ? !pin : 1'b1;
		end
		r.type_stable   = 1'b1;
		r.sample_type   = kind;
		r.accessory_now = acc_state;
		r.switch_value  = sw_model;
	endfunction

	task automatic check_field(input string label, input logic [3:0] want,
		input logic [3:0] got);
		if (want !== got) begin
			if (mismatches < MAX_REPORTS)
				$display("%0t ns: result %0d %s mismatch, expected %0d, actual %0d",
					$time, results_seen, label, want, got);
			mismatches++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t ns: unexpected result word, expected none, actual %h/%b",
						$time, m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want_r = pending_results.pop_front();
				check_field("type_stable",      want_r.type_stable,      m_axis_tuser);
				check_field("sample_type",      want_r.sample_type,      m_axis_tdata[3:0]);
				check_field("accessory_now",    want_r.accessory_now,    m_axis_tdata[7:4]);
				check_field("switch_written",   want_r.switch_written,   m_axis_tdata[8]);
				check_field("switch_value",     want_r.switch_value,     m_axis_tdata[12:9]);
				check_field("headset_event",    want_r.headset_event,    m_axis_tdata[14:13]);
				check_field("usb_path",         want_r.usb_path,         m_axis_tdata[16:15]);
				check_field("charge_clear",     want_r.charge_clear,     m_axis_tdata[17]);
				check_field("host_notify",      want_r.host_notify,      m_axis_tdata[19:18]);
				check_field("irq_enable",       want_r.irq_enable,       m_axis_tdata[20]);
				check_field("irq_trigger_high", want_r.irq_trigger_high, m_axis_tdata[21]);
			end
			results_seen++;
		end
	end

	// output side: random stall bursts plus an on-request long hold
	initial begin : rx_side
		int hold_left;
		int stall_left;
		hold_left  = 0;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req != 0) begin
				hold_left   = rx_hold_req;
				rx_hold_req = 0;
			end
			if ($urandom_range(0, 99) == 0)
				rx_gaps = !rx_gaps;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (rx_gaps && !quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 5);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// offer one sample, wait for the handshake, then log its expectation
	task automatic send_sample(input logic pin, input logic redet,
		input logic [12:0] a, input logic [11:0] s);
		aic_result_t r;
		if (tx_gaps && !quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, s, a};
		s_tuser  <= {redet, pin};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_classification(pin, redet, a, s, r);
		pending_results.push_back(r);
		samples_sent++;
		if (r.type_stable) begin
			accepted_types++;
			kinds_reached[r.accessory_now] = 1'b1;
		end
	endtask

	task automatic pick_sample(input region_t region, output logic pin,
		output logic redet, output logic [12:0] a, output logic [11:0] s);
		pin   = 1'($urandom_range(0, 1));
		redet = 1'($urandom_range(0, 1));
		a     = 13'($urandom);
		s     = 12'($urandom);
		if (region == R_PIN_HIGH) begin
			pin   = 1'b1;
			redet = 1'b0;
		end else if (region != R_NOISE) begin
			if (pin)
				redet = 1'b1;
			case (region)
				R_MHL_WIN: begin
					a = 13'($urandom_range(0, 198)) - 13'd99;
					s = 12'($urandom_range(776, 1020));
				end
				R_DOCK_WIN: begin
					a = 13'($urandom_range(0, 198)) - 13'd99;
					s = 12'($urandom_range(1021, 1224));
				end
				R_OTHER_SECOND: begin
					a = 13'($urandom_range(0, 198)) - 13'd99;
					s = $urandom_range(0, 1) ? 12'($urandom_range(0, 775))
						: 12'($urandom_range(1225, 4095));
				end
				R_CAR:     a = 13'($urandom_range(151, 219));
				R_HEADSET: a = 13'($urandom_range(371, 439));
				R_DMB:     a = 13'($urandom_range(441, 549));
				R_DESK:    a = 13'($urandom_range(551, 899));
				default: begin
					// gaps between the windows, window edges, far negatives
					case ($urandom_range(0, 5))
						0: a = -13'($urandom_range(100, 4096));
						1: a = 13'($urandom_range(100, 150));
						2: a = 13'($urandom_range(220, 370));
						3: a = 13'd440;
						4: a = 13'd550;
						default: a = 13'($urandom_range(900, 4095));
					endcase
				end
			endcase
		end
	endtask

	task automatic send_run(input region_t region, input int count);
		logic pin;
		logic redet;
		logic [12:0] a;
		logic [11:0] s;
		repeat (count) begin
			pick_sample(region, pin, redet, a, s);
			send_sample(pin, redet, a, s);
		end
	endtask

	// stop offering and let the pipe empty before touching registers
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input aic_cfg_t c);
		write_reg(CFG_ADC_DETECT, c.adc_detect_enable);
		write_reg(CFG_MHL_SUPP,   c.mhl_supported);
		write_reg(CFG_MHL_FORCED, c.mhl_forced);
		write_reg(CFG_HOST_SUPP,  c.usb_host_supported);
		write_reg(CFG_HS_DMB_WIN, c.headset_dmb_windows);
		cfg_we  <= 1'b0;
		cur_cfg = c;
		cfg_settings++;
		@(posedge clk);
	endtask

	// window bounds of both readings and the pin-high shortcut
	task automatic test_window_edges();
		int first_edges [15] = '{-4096, -100, -99, 99, 100, 151, 219, 371, 439, 441,
			549, 551, 899, 900, 4095};
		int second_edges [6] = '{775, 776, 1020, 1021, 1224, 1225};
		set_config(aic_cfg_t'(5'b11011));
		foreach (first_edges[i])
			send_sample(1'b0, 1'b0, 13'(first_edges[i]), 12'($urandom));
		foreach (second_edges[i])
			send_sample(1'b0, 1'b0, 13'($urandom_range(0, 198)) - 13'd99,
				12'(second_edges[i]));
		send_sample(1'b1, 1'b0, 13'd160, 12'd0);
		send_sample(1'b1, 1'b1, 13'd160, 12'd4095);
	endtask

	// audio dock forced out by a headset, then MHL removal keeps MHL state
	task automatic test_dock_transitions();
		send_run(R_DOCK_WIN, STABLE_SAMPLES + 1);
		send_run(R_HEADSET, STABLE_SAMPLES + 1);
		send_run(R_MHL_WIN, STABLE_SAMPLES + 1);
		send_run(R_PIN_HIGH, STABLE_SAMPLES + 1);
	endtask

	// long output stall while input keeps coming: input must back off
	task automatic test_backpressure();
		tx_gaps     = 1'b0;
		rx_hold_req = 60;
		send_run(R_CAR, 8);
		send_run(R_DESK, 8);
		send_run(R_NOISE, 8);
		tx_gaps = 1'b1;
	endtask

	task automatic test_random_traffic(input aic_cfg_t c, input int n_items);
		int stop_at;
		region_t region;
		drain();
		set_config(c);
		stop_at = samples_sent + n_items;
		while (samples_sent < stop_at) begin
			if ($urandom_range(0, 79) == 0)
				tx_gaps = !tx_gaps;
			if ($urandom_range(0, 9) == 0) begin
				send_run(R_NOISE, 1);
			end else begin
				region = region_t'($urandom_range(R_PIN_HIGH, R_OUTSIDE));
				if ($urandom_range(0, 4) == 0)
					send_run(region, $urandom_range(1, 3));
				else
					send_run(region, $urandom_range(STABLE_SAMPLES + 1, 8));
			end
		end
	endtask

	task automatic test_quiet_tail();
		quiet   = 1'b1;
		tx_gaps = 1'b0;
		test_random_traffic(aic_cfg_t'(5'b11011), 150);
	endtask

	initial begin
		int waited;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_ADC_DETECT;
		cfg_data  <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_window_edges();
		test_dock_transitions();
		test_backpressure();
		// field order: adc, mhl supported, mhl forced, host supported, hs/dmb windows
		test_random_traffic(aic_cfg_t'(5'b11011), 450);
		test_random_traffic(aic_cfg_t'(5'b11111), 250);
		test_random_traffic(aic_cfg_t'(5'b10000), 300);
		test_random_traffic(aic_cfg_t'(5'b00000), 100);
		test_random_traffic(aic_cfg_t'(5'b01111), 80);
		repeat (4)
			test_random_traffic(aic_cfg_t'({1'b1, 4'($urandom)}), 150);
		test_quiet_tail();

		s_tvalid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t ns: %0d results never arrived, expected 0 outstanding, actual %0d",
				$time, pending_results.size(), pending_results.size());
			mismatches += pending_results.size();
		end

		$display("Ran %0d samples over %0d register settings, %0d accepted types.",
			samples_sent, cfg_settings, accepted_types);
		$display("Accessory states reached (bit per type): %b, with a long output hold.",
			kinds_reached);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("Run timed out with %0d results outstanding.", pending_results.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
